// ----- src/kctt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kctt_pkg
// Shared types, sizes and command codes for the per-key cooldown timer table.
// ----------------------------------------------------------------------------
package kctt_pkg;

  // Table geometry
  localparam int TABLE_SLOTS = 16;
  localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);

  // Field widths
  localparam int CMD_W  = 2;
  localparam int KEY_W  = 8;
  localparam int AMT_W  = 16;
  localparam int HELD_W = 5;

  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [AMT_W-1:0]  amt_t;
  typedef logic [HELD_W-1:0] held_t;
  typedef logic [SLOT_W-1:0] slot_idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // Command codes
  localparam cmd_t CMD_ADD    = 2'd0;
  localparam cmd_t CMD_REMOVE = 2'd1;
  localparam cmd_t CMD_TICK   = 2'd2;
  localparam cmd_t CMD_CLEAR  = 2'd3;

  // Result of the shared slot unit for one slot
  typedef struct packed {
    logic key_hit;   // stored key equals the item key
    logic expire;    // remaining count <= elapsed amount
    amt_t rem_next;  // remaining count minus elapsed amount
  } alu_res_t;

  // Entry count reported on the result, kept to the low five bits
  function automatic held_t to_held(input cnt_t cnt);
    logic [CNT_W+HELD_W-1:0] wide;
    wide = {{HELD_W{1'b0}}, cnt};
    return wide[HELD_W-1:0];
  endfunction

endpackage

// ----- src/kctt_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kctt_in_if / kctt_out_if
// Valid/ready channels for commands into and results out of the timer table.
// ----------------------------------------------------------------------------
interface kctt_in_if;
  logic             valid;
  logic             ready;
  kctt_pkg::cmd_t   command;
  kctt_pkg::key_t   key;
  kctt_pkg::amt_t   amount;

  modport source (output valid, command, key, amount, input ready);
  modport sink   (input valid, command, key, amount, output ready);
endinterface

interface kctt_out_if;
  logic              valid;
  logic              ready;
  logic              ok;
  kctt_pkg::held_t   entries_held;

  modport source (output valid, ok, entries_held, input ready);
  modport sink   (input valid, ok, entries_held, output ready);
endinterface

// ----- src/kctt_slot_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kctt_slot_alu
// Shared per-slot unit: key compare plus one subtract that yields both the
// expiry test and the decremented remaining count.
// ----------------------------------------------------------------------------
module kctt_slot_alu (
  input  kctt_pkg::key_t     slot_key,
  input  kctt_pkg::key_t     key,
  input  kctt_pkg::amt_t     slot_rem,
  input  kctt_pkg::amt_t     amount,
  output kctt_pkg::alu_res_t res
);

  logic [kctt_pkg::AMT_W:0] diff;

  // borrow set or zero result means remaining <= elapsed
  assign diff         = {1'b0, slot_rem} - {1'b0, amount};
  assign res.key_hit  = (slot_key == key);
  assign res.expire   = diff[kctt_pkg::AMT_W] || (diff[kctt_pkg::AMT_W-1:0] == '0);
  assign res.rem_next = diff[kctt_pkg::AMT_W-1:0];

endmodule

// ----- src/key_cooldown_timer_table.sv -----
`timescale 1ns / 1ps
// Operation: add, remove and tick walk every slot once, one slot per cycle through the
//   shared key-compare/subtract unit, then load the result; add passes through a
//   slot-write state before the result. Clear goes straight to the result.
// Flow: one item at a time; the next transfer is taken the cycle after the result is loaded.
// Reset (synchronous, rst_n low): table empty, no result pending, ready to accept.
// ----------------------------------------------------------------------------
// key_cooldown_timer_table
// Table of per-key cooldown timers with add, remove, tick and clear commands.
// ----------------------------------------------------------------------------
module key_cooldown_timer_table (
  input  logic              clk,
  input  logic              rst_n,
  kctt_in_if.sink           in_chan,
  kctt_out_if.source        out_chan
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  localparam kctt_pkg::slot_idx_t LAST_IDX =
    kctt_pkg::slot_idx_t'(kctt_pkg::TABLE_SLOTS - 1);

  // Control state
  logic [1:0]                        state_r, state_nxt;
  kctt_pkg::slot_idx_t               idx_r, idx_nxt;
  logic [kctt_pkg::TABLE_SLOTS-1:0]  valid_r, valid_nxt;
  kctt_pkg::cnt_t                    cnt_r, cnt_nxt;
  logic                              dup_r, dup_nxt;
  logic                              found_r, found_nxt;
  kctt_pkg::slot_idx_t               free_r, free_nxt;
  logic                              ok_r, ok_nxt;
  logic                              out_valid_r, out_valid_nxt;

  // Item and result payload
  kctt_pkg::cmd_t                    cmd_r, cmd_nxt;
  kctt_pkg::key_t                    key_r, key_nxt;
  kctt_pkg::amt_t                    amt_r, amt_nxt;
  logic                              out_ok_r, out_ok_nxt;
  kctt_pkg::held_t                   out_held_r, out_held_nxt;

  // Slot storage
  kctt_pkg::key_t                    key_mem [kctt_pkg::TABLE_SLOTS];
  kctt_pkg::amt_t                    rem_mem [kctt_pkg::TABLE_SLOTS];
  kctt_pkg::key_t                    key_rd_r;
  kctt_pkg::amt_t                    rem_rd_r;
  logic                              key_we;
  logic                              rem_we;
  kctt_pkg::slot_idx_t               wr_addr;
  kctt_pkg::amt_t                    rem_wdata;

  kctt_pkg::alu_res_t                alu_res;
  logic                              in_xfer;

  assign in_chan.ready         = (state_r == S_IDLE);
  assign in_xfer               = in_chan.valid && in_chan.ready;
  assign out_chan.valid        = out_valid_r;
  assign out_chan.ok           = out_ok_r;
  assign out_chan.entries_held = out_held_r;

  kctt_slot_alu u_alu (
    .slot_key (key_rd_r),
    .key      (key_r),
    .slot_rem (rem_rd_r),
    .amount   (amt_r),
    .res      (alu_res)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    valid_nxt     = valid_r;
    cnt_nxt       = cnt_r;
    dup_nxt       = dup_r;
    found_nxt     = found_r;
    free_nxt      = free_r;
    ok_nxt        = ok_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    amt_nxt       = amt_r;
    out_ok_nxt    = out_ok_r;
    out_held_nxt  = out_held_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    key_we        = 1'b0;
    rem_we        = 1'b0;
    wr_addr       = idx_r;
    rem_wdata     = alu_res.rem_next;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_nxt   = in_chan.command;
          key_nxt   = in_chan.key;
          amt_nxt   = in_chan.amount;
          idx_nxt   = '0;
          dup_nxt   = 1'b0;
          found_nxt = 1'b0;
          free_nxt  = '0;
          ok_nxt    = 1'b1;
          if (in_chan.command == kctt_pkg::CMD_CLEAR) begin
            valid_nxt = '0;
            cnt_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      // one slot per cycle
      S_SCAN: begin
        case (cmd_r)
          kctt_pkg::CMD_ADD: begin
            if (valid_r[idx_r] && alu_res.key_hit) begin
              dup_nxt = 1'b1;
            end
            if (!valid_r[idx_r] && !found_r) begin
              found_nxt = 1'b1;
              free_nxt  = idx_r;
            end
          end
          kctt_pkg::CMD_REMOVE: begin
            if (valid_r[idx_r] && alu_res.key_hit && !found_r) begin
              valid_nxt[idx_r] = 1'b0;
              cnt_nxt          = cnt_r - 1'b1;
              found_nxt        = 1'b1;
            end
          end
          kctt_pkg::CMD_TICK: begin
            if (valid_r[idx_r]) begin
              if (alu_res.expire) begin
                valid_nxt[idx_r] = 1'b0;
                cnt_nxt          = cnt_r - 1'b1;
              end else begin
                rem_we = 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
        if (idx_r == LAST_IDX) begin
          state_nxt = (cmd_r == kctt_pkg::CMD_ADD) ? S_WRITE : S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      // place a new key in the lowest free slot
      S_WRITE: begin
        wr_addr   = free_r;
        rem_wdata = amt_r;
        if (!dup_r && found_r) begin
          key_we            = 1'b1;
          rem_we            = 1'b1;
          valid_nxt[free_r] = 1'b1;
          cnt_nxt           = cnt_r + 1'b1;
          ok_nxt            = 1'b1;
        end else begin
          ok_nxt            = 1'b0;
        end
        state_nxt = S_DONE;
      end

      // load the result register once it is free
      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok_r;
          out_held_nxt  = kctt_pkg::to_held(cnt_r);
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      valid_r     <= '0;
      cnt_r       <= '0;
      dup_r       <= 1'b0;
      found_r     <= 1'b0;
      free_r      <= '0;
      ok_r        <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      valid_r     <= valid_nxt;
      cnt_r       <= cnt_nxt;
      dup_r       <= dup_nxt;
      found_r     <= found_nxt;
      free_r      <= free_nxt;
      ok_r        <= ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    amt_r      <= amt_nxt;
    out_ok_r   <= out_ok_nxt;
    out_held_r <= out_held_nxt;
  end

  // Slot storage reads, fetched one slot ahead of the scan
  always_ff @(posedge clk) begin
    key_rd_r <= key_mem[idx_nxt];
    rem_rd_r <= rem_mem[idx_nxt];
  end

  // Slot storage writes
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= key_r;
    end
    if (rem_we) begin
      rem_mem[wr_addr] <= rem_wdata;
    end
  end

endmodule

// ----- dv/key_cooldown_timer_table_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_cooldown_timer_table_test
// Self-checking bench for the cooldown timer table. A short table of directed
// commands covers empty, full, duplicate, zero-delay and boundary-tick cases.
// Random add/remove/tick/clear traffic over a small key pool follows. Typed
// directed rows are checked against their own outcomes, all other results
// against a slot-level table model. Random gaps are drawn on both channels.
// ----------------------------------------------------------------------------
module key_cooldown_timer_table_test;

  localparam int RANDOM_ITEMS   = 850;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int MAX_PRINTS     = 20;

  typedef struct packed {
    logic            ok;
    kctt_pkg::held_t held;
  } outcome_t;

  typedef struct {
    kctt_pkg::cmd_t cmd;
    kctt_pkg::key_t key;
    kctt_pkg::amt_t amt;
    bit             typed;    // expected outcome written into the row
    outcome_t       outcome;
  } stim_row_t;

  logic clk;
  logic rst_n;

  kctt_in_if  in_if ();
  kctt_out_if out_if ();

  key_cooldown_timer_table u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // Model of the table
  bit             slot_live [kctt_pkg::TABLE_SLOTS];
  kctt_pkg::key_t slot_owner[kctt_pkg::TABLE_SLOTS];
  kctt_pkg::amt_t slot_left [kctt_pkg::TABLE_SLOTS];

  outcome_t  pending_q[$];     // outcomes owed by the block, oldest first
  stim_row_t directed_rows[$];

  // Typed expectations of directed rows, in transfer order; the row being
  // driven is always the front entry when its transfer happens
  bit       in_flight_typed[$];
  outcome_t in_flight_exp[$];

  int  mismatch_cnt;
  int  idle_cycles;
  int  cmd_seen[4];
  int  dup_refused;
  int  full_refused;
  int  peak_held;
  bit  no_gaps;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one command to the model and return the outcome it should give
  function automatic outcome_t table_outcome(kctt_pkg::cmd_t c, kctt_pkg::key_t k,
                                             kctt_pkg::amt_t a);
    outcome_t res;
    int       free_slot;
    bit       dup;
    int       held;
    res.ok    = 1'b1;
    free_slot = -1;
    dup       = 1'b0;
    held      = 0;
    cmd_seen[c]++;
    case (c)
      kctt_pkg::CMD_ADD: begin
        for (int i = 0; i < kctt_pkg::TABLE_SLOTS; i++) begin
          if (slot_live[i]) begin
            if (slot_owner[i] == k) dup = 1'b1;
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (dup) begin
          res.ok = 1'b0;
          dup_refused++;
        end else if (free_slot < 0) begin
          res.ok = 1'b0;
          full_refused++;
        end else begin
          slot_live[free_slot]  = 1'b1;
          slot_owner[free_slot] = k;
          slot_left[free_slot]  = a;
        end
      end
      kctt_pkg::CMD_REMOVE: begin
        // keys are unique in the table, so at most one slot matches
        for (int i = 0; i < kctt_pkg::TABLE_SLOTS; i++)
          if (slot_live[i] && slot_owner[i] == k) slot_live[i] = 1'b0;
      end
      kctt_pkg::CMD_TICK: begin
        for (int i = 0; i < kctt_pkg::TABLE_SLOTS; i++) begin
          if (slot_live[i]) begin
            if (slot_left[i] <= a) slot_live[i] = 1'b0;
            else slot_left[i] = slot_left[i] - a;
          end
        end
      end
      default: begin
        for (int i = 0; i < kctt_pkg::TABLE_SLOTS; i++) slot_live[i] = 1'b0;
      end
    endcase
    for (int i = 0; i < kctt_pkg::TABLE_SLOTS; i++) held += slot_live[i];
    if (held > peak_held) peak_held = held;
    res.held = kctt_pkg::held_t'(held);
    return res;
  endfunction

  function automatic int gap_cycles();
    return no_gaps ? 0 : $urandom_range(0, 15);
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Directed row; typed rows carry their expected outcome
  task automatic add_row(input kctt_pkg::cmd_t c, input kctt_pkg::key_t k,
                         input kctt_pkg::amt_t a,
                         input bit typed, input logic ok, input int held);
    stim_row_t row;
    row.cmd          = c;
    row.key          = k;
    row.amt          = a;
    row.typed        = typed;
    row.outcome.ok   = ok;
    row.outcome.held = kctt_pkg::held_t'(held);
    directed_rows.push_back(row);
  endtask

  // Random command; keys mostly from a small pool so duplicates, hits on
  // remove and a full table come up often
  task automatic draw_item(output kctt_pkg::cmd_t c, output kctt_pkg::key_t k,
                           output kctt_pkg::amt_t a);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45)      c = kctt_pkg::CMD_ADD;
    else if (roll < 65) c = kctt_pkg::CMD_REMOVE;
    else if (roll < 96) c = kctt_pkg::CMD_TICK;
    else                c = kctt_pkg::CMD_CLEAR;
    if ($urandom_range(0, 9) < 8) k = kctt_pkg::key_t'($urandom_range(0, 23) * 11);
    else k = kctt_pkg::key_t'($urandom);
    roll = $urandom_range(0, 19);
    if (roll == 0)      a = '0;
    else if (roll == 1) a = '1;
    else if (roll == 2) a = kctt_pkg::amt_t'($urandom);
    else if (c == kctt_pkg::CMD_ADD) a = kctt_pkg::amt_t'($urandom_range(1, 4000));
    else a = kctt_pkg::amt_t'($urandom_range(0, 600));
  endtask

  // Drive one command and hold it until the transfer
  task automatic send_item(input kctt_pkg::cmd_t c, input kctt_pkg::key_t k,
                           input kctt_pkg::amt_t a);
    int gap;
    gap = gap_cycles();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.command <= c;
    in_if.key     <= k;
    in_if.amount  <= a;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // One edge first so the monitor has logged the last input transfer
  task automatic wait_for_results();
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // Transfer monitor: predicts on input transfers, checks result transfers,
  // and ends the run if nothing moves for too long
  always @(posedge clk) begin
    outcome_t exp_out;
    if (!rst_n) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (in_if.valid && in_if.ready) begin
        idle_cycles = 0;
        if (in_flight_typed.size() != 0 && in_flight_typed[0]) begin
          void'(table_outcome(in_if.command, in_if.key, in_if.amount));
          pending_q.push_back(in_flight_exp[0]);
        end else begin
          pending_q.push_back(table_outcome(in_if.command, in_if.key, in_if.amount));
        end
        if (in_flight_typed.size() != 0) begin
          void'(in_flight_typed.pop_front());
          void'(in_flight_exp.pop_front());
        end
      end
      if (out_if.valid && out_if.ready) begin
        idle_cycles = 0;
        if (pending_q.size() == 0) begin
          report_mismatch($sformatf("result ok=%0b held=%0d with nothing expected",
                                    out_if.ok, out_if.entries_held));
        end else begin
          exp_out = pending_q.pop_front();
          if (out_if.ok !== exp_out.ok)
            report_mismatch($sformatf("ok: got %0b, want %0b", out_if.ok, exp_out.ok));
          if (out_if.entries_held !== exp_out.held)
            report_mismatch($sformatf("entries_held: got %0d, want %0d",
                                      out_if.entries_held, exp_out.held));
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, pending_q.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  // Result side: random backpressure
  initial begin
    int gap;
    out_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      gap = gap_cycles();
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  // Main sequence
  initial begin
    kctt_pkg::cmd_t c;
    kctt_pkg::key_t k;
    kctt_pkg::amt_t a;
    mismatch_cnt = 0;
    peak_held    = 0;
    no_gaps      = 1'b0;
    for (int i = 0; i < kctt_pkg::TABLE_SLOTS; i++) slot_live[i] = 1'b0;

    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.command <= kctt_pkg::CMD_CLEAR;
    in_if.key     <= '0;
    in_if.amount  <= '0;

    // Directed table
    add_row(kctt_pkg::CMD_REMOVE, 8'h00, 16'h0000, 1, 1'b1, 0);  // remove on empty table
    add_row(kctt_pkg::CMD_TICK,   8'h00, 16'h0000, 1, 1'b1, 0);  // tick on empty table
    add_row(kctt_pkg::CMD_ADD,    8'h00, 16'h0000, 1, 1'b1, 1);  // zero delay accepted
    add_row(kctt_pkg::CMD_TICK,   8'hFF, 16'h0000, 1, 1'b1, 0);  // zero tick drops it
    add_row(kctt_pkg::CMD_ADD,    8'hFF, 16'hFFFF, 1, 1'b1, 1);
    add_row(kctt_pkg::CMD_ADD,    8'hFF, 16'h0005, 1, 1'b0, 1);  // duplicate refused
    for (int i = 1; i < kctt_pkg::TABLE_SLOTS; i++)
      add_row(kctt_pkg::CMD_ADD, kctt_pkg::key_t'(i), kctt_pkg::amt_t'(i * 16'h1000),
              1, 1'b1, i + 1);
    // table full
    add_row(kctt_pkg::CMD_ADD,    8'h80, 16'h1234, 1, 1'b0, kctt_pkg::TABLE_SLOTS);
    // equal count drops
    add_row(kctt_pkg::CMD_TICK,   8'h00, 16'h1000, 1, 1'b1, kctt_pkg::TABLE_SLOTS - 1);
    add_row(kctt_pkg::CMD_REMOVE, 8'hFF, 16'hFFFF, 1, 1'b1, kctt_pkg::TABLE_SLOTS - 2);
    // reuses freed slot
    add_row(kctt_pkg::CMD_ADD,    8'h80, 16'h1234, 1, 1'b1, kctt_pkg::TABLE_SLOTS - 1);
    add_row(kctt_pkg::CMD_TICK,   8'h00, 16'h7FFF, 0, 1'b1, 0);
    add_row(kctt_pkg::CMD_CLEAR,  8'h5A, 16'hA5A5, 1, 1'b1, 0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      in_flight_typed.push_back(directed_rows[i].typed);
      in_flight_exp.push_back(directed_rows[i].outcome);
      send_item(directed_rows[i].cmd, directed_rows[i].key, directed_rows[i].amt);
    end

    // Hold off until the directed results are all back
    in_if.valid <= 1'b0;
    wait_for_results();

    // Random traffic; gap-free stretches drawn now and then
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_ITEMS / 2) begin
        in_if.valid <= 1'b0;
        wait_for_results();
      end
      draw_item(c, k, a);
      send_item(c, k, a);
    end
    in_if.valid <= 1'b0;

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_q.size() != 0)
      report_mismatch($sformatf("%0d results never came", pending_q.size()));

    $display("covered: %0d add, %0d remove, %0d tick, %0d clear commands",
             cmd_seen[kctt_pkg::CMD_ADD], cmd_seen[kctt_pkg::CMD_REMOVE],
             cmd_seen[kctt_pkg::CMD_TICK], cmd_seen[kctt_pkg::CMD_CLEAR]);
    $display("adds refused: %0d duplicate, %0d table full; peak occupancy %0d",
             dup_refused, full_refused, peak_held);
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
